>>> src/min_coin_change_dp_assert.svh
// Assertion macros shared by the minimum coin change RTL.
`ifndef MIN_COIN_CHANGE_DP_ASSERT_SVH
`define MIN_COIN_CHANGE_DP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define MCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check.
`define MCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/mcc_pkg.sv
// Types, constants and the best-count merge function of the coin change block.
package mcc_pkg;

    localparam int CNT_W         = 10;
    localparam int AMT_W         = 10;
    localparam int ENTRY_W       = 11;
    localparam int NUM_COIN_REGS = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int NCOIN_W       = 3;

    // Bit 10 marks an unreachable amount.
    localparam logic [ENTRY_W-1:0] ENTRY_UNREACH = 11'h400;

    localparam logic [CFG_IDX_W-1:0] REG_COIN_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_LAST    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COINS_IN_USE = 3'd6;

    localparam logic [CNT_W-1:0] COIN_RESET [NUM_COIN_REGS] =
        '{10'd1, 10'd5, 10'd10, 10'd16, 10'd1, 10'd1};
    localparam logic [NCOIN_W-1:0] COINS_IN_USE_RESET = 3'd4;

    // What a token carries for the coin probed in the previous cell.
    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_MEM,
        PEND_ZERO
    } pend_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic               vld;
        logic [AMT_W-1:0]   amount;
        logic [ENTRY_W-1:0] best;
        pend_t              pend;
    } tok_t;

    // Fold one probed entry (plus one coin) into the running best.
    function automatic logic [ENTRY_W-1:0] merge_best(
        input logic [ENTRY_W-1:0] best,
        input pend_t              pend,
        input logic [ENTRY_W-1:0] rd
    );
        logic [ENTRY_W-1:0] prev;
        logic [CNT_W-1:0]   cnt;
        logic               take;
        prev = (pend == PEND_ZERO) ? '0 : rd;
        cnt  = prev[CNT_W-1:0];
        if (cnt != '1)
        begin
            cnt = cnt + 1'b1;
        end
        take = (pend != PEND_NONE) && !prev[ENTRY_W-1] &&
               (best[ENTRY_W-1] || (cnt < best[CNT_W-1:0]));
        return take ? {1'b0, cnt} : best;
    endfunction

endpackage

>>> src/mcc_cell.sv
// One coin cell: merges the previous probe and issues the table read for its coin.
module mcc_cell #(
    parameter int ADDR_W = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcc_pkg::tok_t                 tok_in,
    input  logic [mcc_pkg::CNT_W-1:0]     coin,
    input  logic                          use_coin,
    input  logic [mcc_pkg::ENTRY_W-1:0]   rd_data,
    output logic                          rd_en,
    output logic [ADDR_W-1:0]             rd_addr,
    output mcc_pkg::tok_t                 tok_out
);

    mcc_pkg::tok_t             tok_reg;
    mcc_pkg::tok_t             tok_next;
    mcc_pkg::pend_t            pend_new;
    logic [mcc_pkg::AMT_W-1:0] diff;

    always_comb
    begin
        pend_new = mcc_pkg::PEND_NONE;
        if (use_coin && (coin != '0) && (coin <= tok_in.amount))
        begin
            // exact coin: previous amount is zero, always reachable
            pend_new = (coin == tok_in.amount) ? mcc_pkg::PEND_ZERO : mcc_pkg::PEND_MEM;
        end
        diff            = tok_in.amount - coin;
        rd_addr         = ADDR_W'(diff);
        rd_en           = tok_in.vld && (pend_new == mcc_pkg::PEND_MEM);
        tok_next.vld    = tok_in.vld;
        tok_next.amount = tok_in.amount;
        tok_next.best   = mcc_pkg::merge_best(tok_in.best, tok_in.pend, rd_data);
        tok_next.pend   = pend_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> src/min_coin_change_dp.sv
// Minimum coin change engine: fewest coins from up to six denominations.
// Input channel (in_valid/in_stall/target_amount) takes one request at a time;
// in_stall is high from acceptance until the result has moved into the output
// register. Output channel (out_valid/out_stall/coin_total/unreachable) holds
// the result until taken; the next request may be accepted while it waits.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; index
// 0..5 are the denominations, 6 is coins_in_use, 7 is ignored. Write only
// while idle.
// Operation: the table is rebuilt from amount 1 up to the target. Each amount
// walks a token through MAX_COINS coin cells and one write stage, all sharing
// one table read port; the next amount launches once the last token is written.
// Targets of 0 or beyond the table skip the rebuild. The next request follows
// once the result is registered. Reset returns config to defaults
// (1,5,10,16,1,1; four coins in use) and empties the chain; the table needs no
// clearing since each request writes every entry before reading it. A stalled
// output simply holds its result.
`include "min_coin_change_dp_assert.svh"

module min_coin_change_dp #(
    parameter int MAX_AMOUNT = 1024,
    parameter int MAX_COINS  = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mcc_pkg::AMT_W-1:0]       target_amount,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mcc_pkg::CNT_W-1:0]       coin_total,
    output logic                            unreachable,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcc_pkg::CNT_W-1:0]       cfg_data
);

    localparam int AW = $clog2(MAX_AMOUNT);
    localparam logic [mcc_pkg::NCOIN_W-1:0] MAXC = mcc_pkg::NCOIN_W'(MAX_COINS);

    // ---------------- configuration ----------------
    logic [mcc_pkg::CNT_W-1:0]         coin_reg [mcc_pkg::NUM_COIN_REGS];
    logic [mcc_pkg::NCOIN_W-1:0]       ciu_reg;
    logic [mcc_pkg::NUM_COIN_REGS-1:0] coin_we;
    logic                              ciu_we;
    logic [mcc_pkg::NCOIN_W-1:0]       ncoins;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        coin_we = '0;
        ciu_we  = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index) inside
                [mcc_pkg::REG_COIN_FIRST:mcc_pkg::REG_COIN_LAST]: coin_we[cfg_index] = 1'b1;
                mcc_pkg::REG_COINS_IN_USE: ciu_we = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mcc_pkg::NUM_COIN_REGS; k++)
            begin
                coin_reg[k] <= mcc_pkg::COIN_RESET[k];
            end
            ciu_reg <= mcc_pkg::COINS_IN_USE_RESET;
        end
        else
        begin
            for (int k = 0; k < mcc_pkg::NUM_COIN_REGS; k++)
            begin
                if (coin_we[k])
                begin
                    coin_reg[k] <= cfg_data;
                end
            end
            if (ciu_we)
            begin
                ciu_reg <= cfg_data[mcc_pkg::NCOIN_W-1:0];
            end
        end
    end

    // counts above the cell count clamp to it
    assign ncoins = (ciu_reg > MAXC) ? MAXC : ciu_reg;

    // ---------------- control ----------------
    mcc_pkg::state_t                state_reg;
    mcc_pkg::state_t                state_next;
    logic                           launch_reg;
    logic                           launch_next;
    logic [mcc_pkg::AMT_W-1:0]      amount_reg;
    logic [mcc_pkg::AMT_W-1:0]      amount_next;
    logic [mcc_pkg::AMT_W-1:0]      target_reg;
    logic [mcc_pkg::CNT_W-1:0]      res_total_reg;
    logic                           res_unr_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [mcc_pkg::CNT_W-1:0]      coin_total_reg;
    logic                           unreachable_reg;

    logic                           accept;
    logic                           trivial;
    logic                           out_free;
    logic                           out_load;
    logic                           tail_vld;
    logic                           tail_final;
    logic [mcc_pkg::ENTRY_W-1:0]    tail_best;

    // ---------------- cell chain ----------------
    mcc_pkg::tok_t                  tok [MAX_COINS+1];
    logic [MAX_COINS:0]             chain_vld;
    logic [MAX_COINS-1:0]           cell_rd_en;
    logic [AW-1:0]                  cell_rd_addr [MAX_COINS];
    logic [AW-1:0]                  rd_addr;
    logic [mcc_pkg::ENTRY_W-1:0]    rd_data_reg;
    logic [mcc_pkg::ENTRY_W-1:0]    best_mem [MAX_AMOUNT];

    // a fresh token starts each amount with no coin probed yet
    always_comb
    begin
        tok[0].vld    = launch_reg;
        tok[0].amount = amount_reg;
        tok[0].best   = mcc_pkg::ENTRY_UNREACH;
        tok[0].pend   = mcc_pkg::PEND_NONE;
    end

    for (genvar k = 0; k < MAX_COINS; k++)
    begin : g_cell
        mcc_cell #(
            .ADDR_W (AW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok[k]),
            .coin     (coin_reg[k]),
            .use_coin (mcc_pkg::NCOIN_W'(k) < ncoins),
            .rd_data  (rd_data_reg),
            .rd_en    (cell_rd_en[k]),
            .rd_addr  (cell_rd_addr[k]),
            .tok_out  (tok[k+1])
        );
    end

    // only one token lives in the chain, so the read requests just OR together
    always_comb
    begin
        rd_addr = '0;
        for (int k = 0; k < MAX_COINS; k++)
        begin
            rd_addr = rd_addr | (cell_rd_en[k] ? cell_rd_addr[k] : '0);
        end
        for (int k = 0; k <= MAX_COINS; k++)
        begin
            chain_vld[k] = tok[k].vld;
        end
    end

    // write stage: fold the last probe and store the entry
    assign tail_vld   = tok[MAX_COINS].vld;
    assign tail_best  = mcc_pkg::merge_best(tok[MAX_COINS].best, tok[MAX_COINS].pend,
                                            rd_data_reg);
    assign tail_final = tail_vld && (tok[MAX_COINS].amount == target_reg);

    always_ff @(posedge clk)
    begin
        if (tail_vld)
        begin
            best_mem[AW'(tok[MAX_COINS].amount)] <= tail_best;
        end
        rd_data_reg <= best_mem[rd_addr];
    end

    // ---------------- state machine ----------------
    assign accept   = in_valid && !in_stall;
    assign trivial  = (target_amount == '0) || (32'(target_amount) >= MAX_AMOUNT);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = trivial ? mcc_pkg::ST_HOLD : mcc_pkg::ST_RUN;
                end
            end
            mcc_pkg::ST_RUN:
            begin
                if (tail_final)
                begin
                    state_next = mcc_pkg::ST_HOLD;
                end
            end
            mcc_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = mcc_pkg::ST_IDLE;
                end
            end
            default: state_next = mcc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != mcc_pkg::ST_IDLE);
        out_load = (state_reg == mcc_pkg::ST_HOLD) && out_free;
    end

    always_comb
    begin
        launch_next = (accept && !trivial) || (tail_vld && !tail_final);
        amount_next = amount_reg;
        if (accept)
        begin
            amount_next = mcc_pkg::AMT_W'(1);
        end
        else if (tail_vld && !tail_final)
        begin
            amount_next = tok[MAX_COINS].amount + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcc_pkg::ST_IDLE;
            launch_reg    <= 1'b0;
            amount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            amount_reg    <= amount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg <= target_amount;
        end
        if (accept && trivial)
        begin
            res_total_reg <= '0;
            res_unr_reg   <= (target_amount != '0);
        end
        else if (tail_final)
        begin
            res_unr_reg   <= tail_best[mcc_pkg::ENTRY_W-1];
            res_total_reg <= tail_best[mcc_pkg::ENTRY_W-1] ? '0
                                                           : tail_best[mcc_pkg::CNT_W-1:0];
        end
        if (out_load)
        begin
            coin_total_reg  <= res_total_reg;
            unreachable_reg <= res_unr_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coin_total  = coin_total_reg;
    assign unreachable = unreachable_reg;

    // ---------------- checks ----------------
    `MCC_ASSERT_IMP(a_one_token, clk, rst_n, 1'b1, $onehot0(chain_vld), "two tokens in chain")
    `MCC_ASSERT_IMP(a_tail_in_run, clk, rst_n, tail_vld, state_reg == mcc_pkg::ST_RUN, "stray token")
    `MCC_ASSERT_IMP(a_chain_idle, clk, rst_n, state_reg != mcc_pkg::ST_RUN, chain_vld == '0, "busy chain")
    `MCC_ASSERT_NXT(a_start_run, clk, rst_n, accept && !trivial, launch_reg, "no launch on start")
    `MCC_ASSERT_NXT(a_load_shows, clk, rst_n, out_load, out_valid_reg, "result not presented")

endmodule
